/* rtl/slcf_pkg.sv */
// ----------------------------------------------------------------------------
// slcf_pkg
// Shared types and constants of the sync/length/checksum frame parser.
// ----------------------------------------------------------------------------
package slcf_pkg;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_BYTE      = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WILDCARD_CHECK = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPECIAL_ID     = 8'd3;

  // Register reset values
  localparam logic [7:0] RST_SYNC_BYTE      = 8'hA5;
  localparam logic [6:0] RST_MAX_LENGTH     = 7'h43;
  localparam logic [7:0] RST_WILDCARD_CHECK = 8'hFF;
  localparam logic [7:0] RST_SPECIAL_ID     = 8'h32;

  typedef enum logic [2:0] {
    PH_SYNC    = 3'd0,
    PH_ID      = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_DATA   = 2'd1,
    EV_ACCEPT = 2'd2,
    EV_REJECT = 2'd3
  } event_t;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [6:0] max_length;
    logic [7:0] wildcard_check;
    logic [7:0] special_id;
  } cfg_t;

  typedef struct packed {
    event_t     event_res;
    logic [7:0] frame_id;
    logic [6:0] frame_len;
    logic [7:0] data_byte;
    logic [6:0] data_index;
    logic       special_hit;
    logic       ready_flag;
  } result_t;

endpackage

/* rtl/slcf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// slcf_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module slcf_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [slcf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [slcf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output slcf_pkg::cfg_t                      cfg
);
  import slcf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_byte      <= RST_SYNC_BYTE;
      cfg.max_length     <= RST_MAX_LENGTH;
      cfg.wildcard_check <= RST_WILDCARD_CHECK;
      cfg.special_id     <= RST_SPECIAL_ID;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_BYTE:      cfg.sync_byte      <= cfg_data;
        REG_MAX_LENGTH:     cfg.max_length     <= cfg_data[6:0];
        REG_WILDCARD_CHECK: cfg.wildcard_check <= cfg_data;
        REG_SPECIAL_ID:     cfg.special_id     <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

endmodule

/* rtl/slcf_core.sv */
// ----------------------------------------------------------------------------
// slcf_core
// Parser state machine: one byte step per asserted step strobe.
// ----------------------------------------------------------------------------
module slcf_core #(
  parameter int unsigned BUFFER_DEPTH = 68
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  slcf_pkg::cfg_t    cfg,
  output slcf_pkg::result_t res
);
  import slcf_pkg::*;

  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

  phase_t          phase, phase_next;
  logic [7:0]      held_id, held_id_next;
  logic [15:0]     held_length, held_length_next;
  logic [CW-1:0]   write_cursor, write_cursor_next;
  logic [CW-1:0]   cursor_inc;
  logic [7:0]      running_sum, running_sum_next;
  logic            accepted_seen, accepted_seen_next;
  logic [15:0]     len_assembled;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC;
      held_id       <= '0;
      held_length   <= '0;
      write_cursor  <= '0;
      running_sum   <= '0;
      accepted_seen <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      held_id       <= held_id_next;
      held_length   <= held_length_next;
      write_cursor  <= write_cursor_next;
      running_sum   <= running_sum_next;
      accepted_seen <= accepted_seen_next;
    end
  end

  assign cursor_inc    = write_cursor + CW'(1);
  assign len_assembled = {held_length[7:0], rx_byte};

  always_comb begin
    phase_next         = phase;
    held_id_next       = held_id;
    held_length_next   = held_length;
    write_cursor_next  = write_cursor;
    running_sum_next   = running_sum;
    accepted_seen_next = accepted_seen;
    res.event_res      = EV_NONE;
    res.data_byte      = '0;
    res.data_index     = '0;
    res.special_hit    = 1'b0;

    case (phase)
      PH_SYNC: begin
        if (rx_byte == cfg.sync_byte) begin
          phase_next = PH_ID;
        end
      end
      PH_ID: begin
        held_id_next     = rx_byte;
        running_sum_next = rx_byte;
        phase_next       = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        held_length_next = {8'h00, rx_byte};
        running_sum_next = running_sum + rx_byte;
        phase_next       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        held_length_next = len_assembled;
        running_sum_next = running_sum + rx_byte;
        // oversized length: silent resync
        phase_next = (len_assembled > {9'h000, cfg.max_length}) ? PH_SYNC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        res.event_res  = EV_DATA;
        res.data_byte  = rx_byte;
        res.data_index = 7'(write_cursor);
        // bytes past the declared length are passed out as data but not summed
        if (16'(write_cursor) < held_length) begin
          running_sum_next = running_sum + rx_byte;
        end
        if (16'(cursor_inc) == held_length || cursor_inc >= CW'(BUFFER_DEPTH)) begin
          write_cursor_next = '0;
          phase_next        = PH_CHECK;
        end else begin
          write_cursor_next = cursor_inc;
        end
      end
      PH_CHECK: begin
        if ((~running_sum != rx_byte) && (rx_byte != cfg.wildcard_check)) begin
          res.event_res = EV_REJECT;
        end else begin
          res.event_res      = EV_ACCEPT;
          accepted_seen_next = 1'b1;
          res.special_hit    = (held_id == cfg.special_id);
        end
        phase_next        = PH_SYNC;
        write_cursor_next = '0;
      end
      default: begin
        phase_next = PH_SYNC;
      end
    endcase

    res.frame_id   = held_id_next;
    res.frame_len  = held_length_next[6:0];
    res.ready_flag = accepted_seen_next;
  end

endmodule

/* rtl/sync_length_checksum_frame_parser.sv */
// ----------------------------------------------------------------------------
// sync_length_checksum_frame_parser
// Byte-stream parser for sync / id / length / payload / checksum frames.
// ----------------------------------------------------------------------------
// Path: a byte passes through the input register, then the parser step into the
//   result register. Throughput: one byte per clock while m_tready holds; the
//   parser state machine steps only when a byte waits and the result has a place.
// Reset: rst is synchronous, active high; it clears the parser state, the
//   sticky ready flag, both valid flags and loads the register defaults.
// ----------------------------------------------------------------------------
module sync_length_checksum_frame_parser #(
  parameter int unsigned BUFFER_DEPTH = 68
) (
  input  logic                             clk,
  input  logic                             rst,
  // input byte stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,   // [7:0] rx_byte
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [31:0]                      m_tdata,   // [7:0] frame_id, [14:8] frame_len,
                                                      // [22:15] data_byte, [29:23] data_index,
                                                      // [30] special_hit, [31] ready_flag
  output logic [1:0]                       m_tuser,   // [1:0] event_res
  // configuration write port
  input  logic                             cfg_we,
  input  logic [slcf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [slcf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import slcf_pkg::*;

  cfg_t       cfg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_free;
  logic       step;
  result_t    step_res;
  result_t    out_res;

  // Result register frees up when empty or being taken this cycle.
  assign out_free = !m_tvalid || m_tready;
  // Run one parser step when a byte waits and the result has a place to go.
  assign step     = in_valid && out_free;
  // Take a new byte when the input register is empty or drains now.
  assign s_tready = !in_valid || out_free;

  slcf_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register: hold the byte until the parser step consumes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  slcf_core #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .res     (step_res)
  );

  // Result register: every step yields exactly one word.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= step_res;
    end
  end

  // Pack the word, first field in the lowest bits.
  assign m_tdata = {out_res.ready_flag, out_res.special_hit, out_res.data_index,
                    out_res.data_byte, out_res.frame_len, out_res.frame_id};
  assign m_tuser = out_res.event_res;

endmodule
